// ----- rtl/slot_status_table_core_defines.svh -----
// assertion macros for the slot status table
// no dependencies; taken in by the files that carry checks
`ifndef SLOT_STATUS_TABLE_CORE_DEFINES_SVH
`define SLOT_STATUS_TABLE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define SST_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot status table check failed");

`define SST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot status table check failed");

`else

`define SST_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define SST_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/sst_pkg.sv -----
// shared types, widths and codes of the slot status table
// no dependencies; used by sst_update and slot_status_table_core
package sst_pkg;

   localparam int DEFAULT_MAX_SLOTS = 1024;
   localparam int CAP_RESET         = 1024;

   localparam int OP_W       = 3;
   localparam int SLOT_W     = 10;
   localparam int CNT_W      = 11;
   localparam int MARK_W     = 2;
   localparam int IN_DATA_W  = 16;
   localparam int OUT_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
   localparam logic [OP_W-1:0] OP_ACTIVE  = 3'd2;
   localparam logic [OP_W-1:0] OP_OFFLOAD = 3'd3;
   localparam logic [OP_W-1:0] OP_LOADED  = 3'd4;
   localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

   localparam int MARK_DEL_BIT = 0;
   localparam int MARK_OFF_BIT = 1;

   typedef struct packed {
      logic              err;
      logic [MARK_W-1:0] prior_marks;
      logic [MARK_W-1:0] next_marks;
      logic [CNT_W-1:0]  deleted;
      logic [CNT_W-1:0]  offloaded;
      logic              has_active;
   } upd_type;

endpackage

// ----- rtl/sst_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module sst_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sst_update.sv -----
// next-state and result logic for one slot status request
// depends on sst_pkg
module sst_update (
   input  logic [sst_pkg::OP_W-1:0]   op,
   input  logic                       in_range,
   input  logic [sst_pkg::MARK_W-1:0] marks,
   input  logic [sst_pkg::CNT_W-1:0]  deleted,
   input  logic [sst_pkg::CNT_W-1:0]  offloaded,
   input  logic [sst_pkg::CNT_W-1:0]  cap,
   output sst_pkg::upd_type           upd
);

   logic                       del;
   logic                       off;
   logic                       full;
   logic                       err;
   logic [sst_pkg::CNT_W:0]    sum_now;
   logic [sst_pkg::CNT_W:0]    sum_next;
   logic [sst_pkg::CNT_W-1:0]  nd;
   logic [sst_pkg::CNT_W-1:0]  no;
   logic [sst_pkg::CNT_W-1:0]  fd;
   logic [sst_pkg::CNT_W-1:0]  fo;
   logic [sst_pkg::MARK_W-1:0] nm;

   assign del     = marks[sst_pkg::MARK_DEL_BIT];
   assign off     = marks[sst_pkg::MARK_OFF_BIT];
   assign sum_now = {1'b0, deleted} + {1'b0, offloaded};
   // one more mark would exceed capacity
   assign full    = sum_now >= {1'b0, cap};

   always_comb begin
      nd  = deleted;
      no  = offloaded;
      nm  = marks;
      err = 1'b0;
      unique case (op)
         sst_pkg::OP_CLEAR: begin
            if (del) nd = deleted - 1'b1;
            if (off) no = offloaded - 1'b1;
            nm = '0;
         end
         sst_pkg::OP_DELETE: begin
            if (del || full) err = 1'b1;
            else begin
               nm[sst_pkg::MARK_DEL_BIT] = 1'b1;
               nd = deleted + 1'b1;
            end
         end
         sst_pkg::OP_ACTIVE: begin
            if (!del) err = 1'b1;
            else begin
               nm[sst_pkg::MARK_DEL_BIT] = 1'b0;
               nd = deleted - 1'b1;
            end
         end
         sst_pkg::OP_OFFLOAD: begin
            if (del || off || full) err = 1'b1;
            else begin
               nm[sst_pkg::MARK_OFF_BIT] = 1'b1;
               no = offloaded + 1'b1;
            end
         end
         sst_pkg::OP_LOADED: begin
            if (del || !off) err = 1'b1;
            else begin
               nm[sst_pkg::MARK_OFF_BIT] = 1'b0;
               no = offloaded - 1'b1;
            end
         end
         sst_pkg::OP_QUERY: begin
            nm = marks;
         end
         default: begin
            err = 1'b1;
         end
      endcase
      if (!in_range) err = 1'b1;
   end

   assign fd       = err ? deleted : nd;
   assign fo       = err ? offloaded : no;
   assign sum_next = {1'b0, fd} + {1'b0, fo};

   assign upd.err         = err;
   assign upd.prior_marks = in_range ? marks : '0;
   assign upd.next_marks  = nm;
   assign upd.deleted     = fd;
   assign upd.offloaded   = fo;
   assign upd.has_active  = sum_next < {1'b0, cap};

endmodule

// ----- rtl/slot_status_table_core.sv -----
// slot status table: deleted and offloaded marks per slot, with counts
// depends on sst_pkg, sst_ram, sst_update and slot_status_table_core_defines.svh
//
//  port group  dir  tdata / data           tuser
//  req_*       in   slot                   op
//  rsp_*       out  marks, counts, active  error
//  csr_*       in   capacity_in_use        -
//
// one request per cycle sustained while responses are taken; acceptance loads s1, s1 firing loads rsp_tvalid
// the mark ram read at acceptance and the write-back as s1 fires set the pace;
// a write forwarding register covers back-to-back requests to the same slot
// after reset a clearing pass writes zero marks to all MAX_SLOTS slots, no request taken
// a stalled response holds the request in flight; req_tready drops behind it
`include "slot_status_table_core_defines.svh"

module slot_status_table_core #(
   parameter int MAX_SLOTS = sst_pkg::DEFAULT_MAX_SLOTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [9:0] slot, rest zero
   input  logic [sst_pkg::IN_DATA_W-1:0]   req_tdata,
   // [2:0] op
   input  logic [sst_pkg::OP_W-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] was_deleted, [1] was_offloaded, [12:2] deleted_total,
   // [23:13] offloaded_total, [24] has_active, rest zero
   output logic [sst_pkg::OUT_DATA_W-1:0]  rsp_tdata,
   // [0] error
   output logic                            rsp_tuser,
   input  logic                            csr_wr_en,
   input  logic [sst_pkg::CNT_W-1:0]       csr_wr_data
);

   localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int EXT_W  = sst_pkg::SLOT_W + ADDR_W;
   localparam int CAP_RST =
      (MAX_SLOTS < sst_pkg::CAP_RESET) ? MAX_SLOTS : sst_pkg::CAP_RESET;
   localparam logic [ADDR_W-1:0]         CLR_LAST = ADDR_W'(MAX_SLOTS - 1);
   localparam logic [sst_pkg::CNT_W-1:0] CAP_INIT = sst_pkg::CNT_W'(CAP_RST);

   logic                            clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0]               clr_addr_ff, clr_addr_in;
   logic [sst_pkg::CNT_W-1:0]       cap_ff, cap_in;
   logic [sst_pkg::CNT_W-1:0]       deleted_ff, deleted_in;
   logic [sst_pkg::CNT_W-1:0]       offloaded_ff, offloaded_in;
   logic                            s1_valid_ff, s1_valid_in;
   logic [sst_pkg::OP_W-1:0]        s1_op_ff;
   logic [sst_pkg::SLOT_W-1:0]      s1_slot_ff;
   logic                            fwd_valid_ff;
   logic [ADDR_W-1:0]               fwd_addr_ff;
   logic [sst_pkg::MARK_W-1:0]      fwd_data_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sst_pkg::OUT_DATA_W-1:0]  rsp_data_ff;
   logic                            rsp_err_ff;

   logic                            rsp_free;
   logic                            s1_fire;
   logic                            req_fire;
   logic [EXT_W-1:0]                req_slot_ext;
   logic [EXT_W-1:0]                s1_slot_ext;
   logic [ADDR_W-1:0]               req_addr;
   logic [ADDR_W-1:0]               s1_addr;
   logic [sst_pkg::MARK_W-1:0]      ram_rd_data;
   logic [sst_pkg::MARK_W-1:0]      s1_marks;
   logic                            s1_in_range;
   logic                            ram_we;
   logic [ADDR_W-1:0]               ram_wr_addr;
   logic [sst_pkg::MARK_W-1:0]      ram_wr_data;
   sst_pkg::upd_type                upd;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && rsp_free;
   assign req_tready = !clr_active_ff && (!s1_valid_ff || s1_fire);
   assign req_fire   = req_tvalid && req_tready;

   assign req_slot_ext = EXT_W'(req_tdata[sst_pkg::SLOT_W-1:0]);
   assign s1_slot_ext  = EXT_W'(s1_slot_ff);
   assign req_addr     = req_slot_ext[ADDR_W-1:0];
   assign s1_addr      = s1_slot_ext[ADDR_W-1:0];

   assign s1_marks    = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_data_ff
                                                                    : ram_rd_data;
   assign s1_in_range = {1'b0, s1_slot_ff} < cap_ff;

   sst_update u_update (
      .op        (s1_op_ff),
      .in_range  (s1_in_range),
      .marks     (s1_marks),
      .deleted   (deleted_ff),
      .offloaded (offloaded_ff),
      .cap       (cap_ff),
      .upd       (upd)
   );

   assign ram_we      = clr_active_ff || (s1_fire && !upd.err);
   assign ram_wr_addr = clr_active_ff ? clr_addr_ff : s1_addr;
   assign ram_wr_data = clr_active_ff ? '0 : upd.next_marks;

   sst_ram #(
      .WIDTH (sst_pkg::MARK_W),
      .DEPTH (MAX_SLOTS)
   ) u_marks (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == CLR_LAST) clr_active_in = 1'b0;
      end
   end

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr_en) begin
         if (32'(csr_wr_data) < MAX_SLOTS) cap_in = csr_wr_data;
         else cap_in = sst_pkg::CNT_W'(MAX_SLOTS);
      end
   end

   assign deleted_in   = (s1_fire && !upd.err) ? upd.deleted : deleted_ff;
   assign offloaded_in = (s1_fire && !upd.err) ? upd.offloaded : offloaded_ff;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         cap_ff        <= CAP_INIT;
         deleted_ff    <= '0;
         offloaded_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         cap_ff        <= cap_in;
         deleted_ff    <= deleted_in;
         offloaded_ff  <= offloaded_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (ram_we) fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_tuser;
         s1_slot_ff <= req_tdata[sst_pkg::SLOT_W-1:0];
      end
      if (ram_we) begin
         fwd_addr_ff <= ram_wr_addr;
         fwd_data_ff <= ram_wr_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= sst_pkg::OUT_DATA_W'({upd.has_active, upd.offloaded, upd.deleted,
                                              upd.prior_marks[sst_pkg::MARK_OFF_BIT],
                                              upd.prior_marks[sst_pkg::MARK_DEL_BIT]});
         rsp_err_ff  <= upd.err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   `SST_ASSERT_IMPLY(a_no_req_in_clear, clock, reset, clr_active_ff, !req_tready && !s1_valid_ff)
   `SST_ASSERT_IMPLY(a_sum_bounded, clock, reset, 1'b1,
      (32'(deleted_ff) + 32'(offloaded_ff)) <= MAX_SLOTS)
   `SST_ASSERT_NEXT(a_err_keeps_counts, clock, reset, s1_fire && upd.err,
      $stable(deleted_ff) && $stable(offloaded_ff))
   `SST_ASSERT_IMPLY(a_write_only_legal, clock, reset, ram_we && !clr_active_ff, s1_fire && !upd.err)
   `SST_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, s1_fire, rsp_valid_ff)

endmodule
